### rtl/core/gliding_sine_oscillator_unit_defines.svh
// Assertion macros used by the oscillator back end (gso_back).
// Both expect clk and rst_n in the enclosing scope.
`ifndef GLIDING_SINE_OSCILLATOR_UNIT_DEFINES_SVH
`define GLIDING_SINE_OSCILLATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GSO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gso_pkg.sv
`default_nettype none
package gso_pkg;

  localparam int TARGET_W  = 24;
  localparam int AMP_W     = 16;
  localparam int CFG_W     = 16;
  localparam int STEP_W    = 32;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_KEEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_TAKE = 1'd1;

  localparam logic [CFG_W-1:0] GLIDE_KEEP_RST = 16'd58982;
  localparam logic [CFG_W-1:0] GLIDE_TAKE_RST = 16'd6554;

  // Front queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic                block_start;
    logic [TARGET_W-1:0] target_increment;
    logic [AMP_W-1:0]    amplitude;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] glide_keep;
    logic [CFG_W-1:0] glide_take;
  } cfg_t;

  // Quarter-wave sine entry j, evaluated at elaboration only.
  function automatic logic [63:0] quarter_sine(input logic [63:0] j,
                                               input int unsigned qshift,
                                               input int unsigned sample_bits);
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    m    = (64'd1 << (sample_bits - 1)) - 64'd1;
    x    = (HALF_PI_Q30 * j + ((64'd1 << qshift) >> 1)) >> qshift;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * m + (64'd1 << 29)) >> 30;
    if (v > m) begin
      v = m;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/gso_front.sv
`default_nettype none
module gso_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire gso_pkg::item_t  in_item,
  output logic                 in_stall,
  output logic                 item_valid,
  output gso_pkg::item_t       item_out,
  input  wire logic            item_take
);

  gso_pkg::item_t                   slot_r [0:gso_pkg::QUEUE_DEPTH-1];
  logic [gso_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             wr_ptr_r, rd_ptr_r;
  logic                             push, pop;

  // full queue holds off the source
  assign in_stall   = (count_r == gso_pkg::QCNT_W'(gso_pkg::QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign item_valid = (count_r != '0);
  assign pop        = item_take && item_valid;
  assign item_out   = slot_r[rd_ptr_r];

  assign count_nxt = gso_pkg::QCNT_W'(count_r + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gso_back.sv
`default_nettype none
`include "gliding_sine_oscillator_unit_defines.svh"
module gso_back #(
  parameter int PHASE_BITS      = 24,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gso_pkg::cfg_t               cfg,
  input  wire logic                        item_valid,
  input  wire gso_pkg::item_t              item_in,
  output logic                             item_take,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [gso_pkg::OUT_W-1:0] out_sample
);

  localparam int QBITS  = TABLE_ADDR_BITS - 2;
  localparam int QSIZE  = 1 << QBITS;
  localparam int MAG_W  = SAMPLE_BITS - 1;
  localparam int PROD_W = MAG_W + gso_pkg::AMP_W;
  localparam int KP_W   = gso_pkg::CFG_W + gso_pkg::STEP_W;
  localparam int TP_W   = gso_pkg::CFG_W + gso_pkg::TARGET_W;
  localparam int BL_W   = KP_W + 1;
  localparam logic [SAMPLE_BITS:0] POS_LIM = (SAMPLE_BITS + 1)'((1 << MAG_W) - 1);
  localparam logic [SAMPLE_BITS:0] NEG_LIM = (SAMPLE_BITS + 1)'(1 << MAG_W);

  typedef logic [QSIZE:0][MAG_W-1:0] qrom_t;

  function automatic qrom_t build_qrom();
    qrom_t r;
    for (int j = 0; j <= QSIZE; j++) begin
      r[j] = MAG_W'(gso_pkg::quarter_sine(64'(j), QBITS, SAMPLE_BITS));
    end
    return r;
  endfunction

  localparam qrom_t QROM = build_qrom();

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_GLIDE = 6'b000010,
    ST_PHASE = 6'b000100,
    ST_ROM   = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [gso_pkg::AMP_W-1:0]       amp_r;
  logic [KP_W-1:0]                 prod_keep_r;
  logic [TP_W-1:0]                 prod_take_r;
  logic [BL_W-1:0]                 blend_sum;
  logic [gso_pkg::STEP_W:0]        blend_shr;
  logic [gso_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [63:0]                     step_wide;
  logic [PHASE_BITS-1:0]           step_units;
  logic [PHASE_BITS-1:0]           phase_r, phase_nxt;
  logic [63:0]                     phase_wide;
  logic [TABLE_ADDR_BITS-1:0]      tab_addr;
  logic [QBITS-1:0]                rom_j;
  logic [QBITS:0]                  rom_idx;
  logic [MAG_W-1:0]                rom_mag_r;
  logic                            rom_neg_r;
  logic [PROD_W-1:0]               prod_r;
  logic [PROD_W:0]                 rounded;
  logic [SAMPLE_BITS:0]            scaled, neg_mag;
  logic [SAMPLE_BITS-1:0]          val;
  logic [gso_pkg::OUT_W-1:0]       sample16;
  logic                            out_valid_r;
  logic [gso_pkg::OUT_W-1:0]       out_sample_r;
  logic                            out_free, out_load;

  assign item_take = (state_r == ST_IDLE) && item_valid;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_DONE) && out_free;

  // glide blend with round-half-up, saturate to the step width
  assign blend_sum = BL_W'(prod_keep_r) + BL_W'(prod_take_r) + BL_W'(32768);
  assign blend_shr = blend_sum[BL_W-1:16];

  assign step_wide = 64'(step_r);
  generate
    if (PHASE_BITS >= gso_pkg::TARGET_W) begin : g_step_up
      assign step_units = PHASE_BITS'(step_wide << (PHASE_BITS - gso_pkg::TARGET_W));
    end else begin : g_step_dn
      assign step_units = step_wide[gso_pkg::TARGET_W-PHASE_BITS +: PHASE_BITS];
    end
  endgenerate

  assign phase_wide = 64'(phase_r);
  generate
    if (PHASE_BITS >= TABLE_ADDR_BITS) begin : g_addr_dn
      assign tab_addr = phase_wide[PHASE_BITS-TABLE_ADDR_BITS +: TABLE_ADDR_BITS];
    end else begin : g_addr_up
      assign tab_addr = {phase_r, {(TABLE_ADDR_BITS - PHASE_BITS){1'b0}}};
    end
  endgenerate

  // quarter-wave fold: odd quadrants mirror, upper half negates
  assign rom_j   = tab_addr[QBITS-1:0];
  assign rom_idx = tab_addr[QBITS] ? ((QBITS + 1)'(QSIZE) - {1'b0, rom_j})
                                   : {1'b0, rom_j};

  // gain rounding: halves go away from zero on the magnitude
  assign rounded = (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(16384);
  assign scaled  = rounded[PROD_W:15];
  assign neg_mag = (SAMPLE_BITS + 1)'(~scaled + (SAMPLE_BITS + 1)'(1));

  always_comb begin
    if (rom_neg_r) begin
      val = (scaled > NEG_LIM) ? {1'b1, {MAG_W{1'b0}}} : neg_mag[SAMPLE_BITS-1:0];
    end else begin
      val = (scaled > POS_LIM) ? {1'b0, {MAG_W{1'b1}}} : scaled[SAMPLE_BITS-1:0];
    end
  end

  generate
    if (SAMPLE_BITS >= gso_pkg::OUT_W) begin : g_out_dn
      assign sample16 = val[SAMPLE_BITS-1 -: gso_pkg::OUT_W];
    end else begin : g_out_up
      assign sample16 = {val, {(gso_pkg::OUT_W - SAMPLE_BITS){1'b0}}};
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          state_nxt = item_in.block_start ? ST_GLIDE : ST_PHASE;
        end
      end
      ST_GLIDE: begin
        step_nxt  = blend_shr[gso_pkg::STEP_W] ? '1 : blend_shr[gso_pkg::STEP_W-1:0];
        state_nxt = ST_PHASE;
      end
      ST_PHASE: begin
        phase_nxt = phase_r + step_units;
        state_nxt = ST_ROM;
      end
      ST_ROM: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      amp_r       <= item_in.amplitude;
      prod_keep_r <= KP_W'(cfg.glide_keep * step_r);
      prod_take_r <= TP_W'(cfg.glide_take * item_in.target_increment);
    end
    if (state_r == ST_ROM) begin
      rom_mag_r <= QROM[rom_idx];
      rom_neg_r <= tab_addr[QBITS+1];
    end
    if (state_r == ST_SCALE) begin
      prod_r <= PROD_W'(rom_mag_r * amp_r);
    end
    if (out_load) begin
      out_sample_r <= sample16;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  `GSO_ASSERT_NEXT(a_step_hold, state_r != ST_GLIDE, $stable(step_r), "step moved outside glide")
  `GSO_ASSERT_NEXT(a_phase_hold, state_r != ST_PHASE, $stable(phase_r), "phase moved outside add")
  `GSO_ASSERT_NEXT(a_glide_path, item_take, (state_r == ST_GLIDE) == $past(item_in.block_start), "glide path mismatch")
  `GSO_ASSERT_IMPL(a_load_from_done, $rose(out_valid_r), $past(state_r == ST_DONE), "result loaded early")

endmodule
`default_nettype wire

### rtl/core/gliding_sine_oscillator_unit.sv
// Gliding sine oscillator: one transaction in is one sample tick and gives one
// signed 16-bit sample out, meant for both stereo channels. A tick with
// block_start set first blends the kept phase step toward target_increment
// (keep*step + take*target, Q0.16 weights, rounded, saturated at 32 bits);
// every tick then advances the phase accumulator by the step, reads the
// quarter-wave sine ROM at the new phase, scales by amplitude (Q1.15, halves
// rounded away from zero) and saturates. The back-end sequencer runs these
// steps in order, the blend add only with block_start set: blend multiply,
// blend add, phase add, registered ROM read, gain multiply, then round and
// saturate into the output register. A two-deep queue in front accepts
// transactions while the sequencer works, and the output register holds a
// finished sample while the sink stalls, so the next tick keeps moving. The
// sine table is built at elaboration from TABLE_ADDR_BITS and SAMPLE_BITS.
// Write the glide_keep (index 0) and glide_take (index 1) registers only
// while no tick is in flight; a write takes effect on the next tick.
`default_nettype none
module gliding_sine_oscillator_unit #(
  parameter int PHASE_BITS      = 24,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_block_start,
  input  wire logic [gso_pkg::TARGET_W-1:0]           in_target_increment,
  input  wire logic [gso_pkg::AMP_W-1:0]              in_amplitude,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [gso_pkg::OUT_W-1:0]            out_sample,
  input  wire logic                                   cfg_we,
  input  wire logic [gso_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [gso_pkg::CFG_W-1:0]              cfg_wdata
);

  gso_pkg::cfg_t  cfg_r;
  gso_pkg::item_t in_item;
  gso_pkg::item_t q_item;
  logic           q_valid;
  logic           q_take;

  // Glide weights: take the write on the enable edge, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glide_keep <= gso_pkg::GLIDE_KEEP_RST;
      cfg_r.glide_take <= gso_pkg::GLIDE_TAKE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gso_pkg::CFG_GLIDE_KEEP: cfg_r.glide_keep <= cfg_wdata;
        gso_pkg::CFG_GLIDE_TAKE: cfg_r.glide_take <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Bundle the input fields into one queue entry.
  assign in_item.block_start      = in_block_start;
  assign in_item.target_increment = in_target_increment;
  assign in_item.amplitude        = in_amplitude;

  // Front: accept and queue ticks.
  gso_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .item_valid (q_valid),
    .item_out   (q_item),
    .item_take  (q_take)
  );

  // Back: glide, phase, table, gain, output register.
  gso_back #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item_in    (q_item),
    .item_take  (q_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

endmodule
`default_nettype wire

### bench/gliding_sine_oscillator_unit_test.sv
`timescale 1ns / 1ps

module gliding_sine_oscillator_unit_test;

  localparam int QTR_SIZE = 256;          // quarter-wave entries: 2^(10-2)
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // One sample tick as offered on the input channel.
  typedef struct packed {
    logic                         start;
    logic [gso_pkg::TARGET_W-1:0] tgt;
    logic [gso_pkg::AMP_W-1:0]    amp;
  } tick_t;

  // Directed row: the tick plus, where it is obvious, the sample it must give.
  typedef struct {
    logic                             start;
    logic [gso_pkg::TARGET_W-1:0]     tgt;
    logic [gso_pkg::AMP_W-1:0]        amp;
    bit                               typed;
    logic signed [gso_pkg::OUT_W-1:0] want;
  } dir_row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic                              in_block_start;
  logic [gso_pkg::TARGET_W-1:0]      in_target_increment;
  logic [gso_pkg::AMP_W-1:0]         in_amplitude;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [gso_pkg::OUT_W-1:0]  out_sample;
  logic                              cfg_we;
  logic [gso_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [gso_pkg::CFG_W-1:0]         cfg_wdata;

  // Oscillator model state and its copy of the glide weights.
  logic [23:0]                       nco_phase;
  logic [gso_pkg::STEP_W-1:0]        nco_step;
  logic [gso_pkg::CFG_W-1:0]         keep_wt;
  logic [gso_pkg::CFG_W-1:0]         take_wt;
  longint unsigned                   sine_quarter [0:QTR_SIZE];

  logic signed [gso_pkg::OUT_W-1:0]  expected_samples [$];
  int                                fails;
  int                                src_run;
  int                                snk_run;

  // Directed ticks. The first two come straight after reset with a zero step,
  // so the phase sits at zero and the sample is zero. Zero gain also reads
  // as zero; everything else goes through the model.
  dir_row_t directed_rows [18] = '{
    '{1'b0, 24'hFFFFFF, 16'd32768, 1'b1, 16'sd0},
    '{1'b0, 24'h000000, 16'd65535, 1'b1, 16'sd0},
    '{1'b1, 24'h400000, 16'd32768, 1'b0, 16'sd0},
    '{1'b0, 24'h400000, 16'd0,     1'b1, 16'sd0},
    '{1'b0, 24'h123456, 16'd32767, 1'b0, 16'sd0},
    '{1'b1, 24'hFFFFFF, 16'd65535, 1'b0, 16'sd0},
    '{1'b0, 24'h000000, 16'd1,     1'b0, 16'sd0},
    '{1'b1, 24'h000000, 16'd32768, 1'b0, 16'sd0},
    '{1'b0, 24'h800000, 16'd16384, 1'b0, 16'sd0},
    '{1'b1, 24'hAAAAAA, 16'd43690, 1'b0, 16'sd0},
    '{1'b0, 24'h555555, 16'd21845, 1'b0, 16'sd0},
    '{1'b1, 24'h000001, 16'd32768, 1'b0, 16'sd0},
    '{1'b0, 24'h000001, 16'd32769, 1'b0, 16'sd0},
    '{1'b1, 24'h7FFFFF, 16'd65535, 1'b0, 16'sd0},
    '{1'b0, 24'h800000, 16'd32768, 1'b0, 16'sd0},
    '{1'b1, 24'hFFFFFF, 16'd0,     1'b1, 16'sd0},
    '{1'b0, 24'hC00000, 16'd32768, 1'b0, 16'sd0},
    '{1'b1, 24'h3FFFFF, 16'd40000, 1'b0, 16'sd0}
  };

  gliding_sine_oscillator_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_block_start      (in_block_start),
    .in_target_increment (in_target_increment),
    .in_amplitude        (in_amplitude),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sample          (out_sample),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Draw an idle count: mostly 0..11, with occasional runs of back-to-back
  // transactions so that some stretches see no idling at all.
  function automatic int pick_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = 24;
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Advance the oscillator model by one tick and return its sample.
  function automatic logic signed [gso_pkg::OUT_W-1:0] next_sample(input tick_t t);
    logic [63:0] blend;
    logic [9:0]  addr;
    logic [7:0]  j;
    logic [63:0] rom;
    logic [63:0] mag;
    int          val;
    // Glide first on a buffer start; the blend may exceed one, so clamp.
    if (t.start) begin
      blend = 64'(keep_wt) * 64'(nco_step) + 64'(take_wt) * 64'(t.tgt) + 64'd32768;
      blend = blend >> 16;
      nco_step = (blend > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : blend[31:0];
    end
    // Phase wraps at one cycle; only the low 24 bits of the step matter.
    nco_phase = nco_phase + nco_step[23:0];
    addr = nco_phase[23:14];
    j    = addr[7:0];
    // Odd quadrants mirror the index, the lower half-wave negates.
    rom = addr[8] ? sine_quarter[QTR_SIZE - int'(j)] : sine_quarter[j];
    mag = (rom * 64'(t.amp) + 64'd16384) >> 15;
    if (addr[9]) begin
      val = (mag > 64'd32768) ? -32768 : -int'(mag);
    end else begin
      val = (mag > 64'd32767) ? 32767 : int'(mag);
    end
    return gso_pkg::OUT_W'(val);
  endfunction

  // Offer one transaction after a random gap and hold it until it is taken.
  task automatic offer_tick(input tick_t t, input bit typed,
                            input logic signed [gso_pkg::OUT_W-1:0] typed_val);
    int                               gap;
    logic signed [gso_pkg::OUT_W-1:0] pred;
    gap = pick_wait(src_run);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_block_start      <= t.start;
    in_target_increment <= t.tgt;
    in_amplitude        <= t.amp;
    do @(posedge clk); while (in_stall);
    // Advance the model even on typed rows so its state stays in step.
    pred = next_sample(t);
    expected_samples.push_back(typed ? typed_val : pred);
  endtask

  // Random ticks. Heavy glide keeps block_start mostly set with targets near
  // a full cycle, which drives the kept step into saturation.
  task automatic run_ticks(input int count, input bit heavy_glide);
    tick_t t;
    for (int k = 0; k < count; k++) begin
      if (heavy_glide) begin
        t.start = ($urandom_range(0, 7) != 0);
        t.tgt   = {8'hFF, 16'($urandom)};
      end else begin
        t.start = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 3))
          0: t.tgt = 24'($urandom_range(0, 24'h00FFFF));
          1: t.tgt = 24'($urandom);
          2: t.tgt = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF :
                     (($urandom_range(0, 1) != 0) ? 24'h800000 : 24'h000000);
          default: t.tgt = 24'($urandom_range(0, 24'h0FFFFF));
        endcase
      end
      case ($urandom_range(0, 9))
        7: t.amp = 16'd32768;
        8: t.amp = 16'd0;
        9: t.amp = 16'($urandom_range(32769, 65535));
        default: t.amp = 16'($urandom_range(0, 32768));
      endcase
      offer_tick(t, 1'b0, '0);
    end
  endtask

  // Drop valid and wait until every sample in flight has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Write one glide weight while the block is idle; mirror it in the model.
  task automatic write_reg(input logic [gso_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gso_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == gso_pkg::CFG_GLIDE_KEEP) begin
      keep_wt = data;
    end else if (idx == gso_pkg::CFG_GLIDE_TAKE) begin
      take_wt = data;
    end
  endtask

  // Result side: stall per transaction, check each accepted sample in order.
  initial begin : sink
    int                               hold;
    int                               got;
    logic signed [gso_pkg::OUT_W-1:0] want;
    hold = 0;
    got  = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("sample: none expected, actual %0d", out_sample);
          fails++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want) begin
            $error("sample: expected %0d, actual %0d", want, out_sample);
            fails++;
          end
        end
        got++;
        // Now and then hold off long enough that the front queue fills and
        // the input side has to stall.
        hold = (got % 450 == 200) ? 150 : pick_wait(snk_run);
      end
    end
  end

  initial begin : stimulus
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    tick_t       t;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_block_start      = 1'b0;
    in_target_increment = '0;
    in_amplitude        = '0;
    out_stall           = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = gso_pkg::CFG_GLIDE_KEEP;
    cfg_wdata           = '0;
    fails               = 0;
    src_run             = 0;
    snk_run             = 0;

    // Build the quarter-wave table: Taylor series of sin up to x^15 in Q30,
    // then scaled to the 16-bit peak with rounding and a clamp.
    for (int j = 0; j <= QTR_SIZE; j++) begin
      x    = (PI_HALF_Q30 * 64'(j) + 64'd128) >> 8;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + 64'd536870912) >> 30;
      sine_quarter[j] = (v > 64'd32767) ? 64'd32767 : v;
    end

    // Model state after reset.
    nco_phase = '0;
    nco_step  = '0;
    keep_wt   = gso_pkg::GLIDE_KEEP_RST;
    take_wt   = gso_pkg::GLIDE_TAKE_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks on the reset weights, then random ones.
    foreach (directed_rows[i]) begin
      t.start = directed_rows[i].start;
      t.tgt   = directed_rows[i].tgt;
      t.amp   = directed_rows[i].amp;
      offer_tick(t, directed_rows[i].typed, directed_rows[i].want);
    end
    run_ticks(150, 1'b0);

    // Both weights zero: every buffer start collapses the step to zero.
    settle();
    write_reg(gso_pkg::CFG_GLIDE_KEEP, 16'd0);
    write_reg(gso_pkg::CFG_GLIDE_TAKE, 16'd0);
    run_ticks(150, 1'b0);

    // Both weights at maximum: the step climbs until it clamps at 32 bits.
    settle();
    write_reg(gso_pkg::CFG_GLIDE_KEEP, 16'hFFFF);
    write_reg(gso_pkg::CFG_GLIDE_TAKE, 16'hFFFF);
    run_ticks(300, 1'b1);

    // Jump almost straight to the target on each buffer start.
    settle();
    write_reg(gso_pkg::CFG_GLIDE_KEEP, 16'd0);
    write_reg(gso_pkg::CFG_GLIDE_TAKE, 16'hFFFF);
    run_ticks(200, 1'b0);

    // Ignore the target and let the step decay slowly.
    settle();
    write_reg(gso_pkg::CFG_GLIDE_KEEP, 16'hFFFF);
    write_reg(gso_pkg::CFG_GLIDE_TAKE, 16'd0);
    run_ticks(150, 1'b0);

    // Arbitrary weights.
    settle();
    write_reg(gso_pkg::CFG_GLIDE_KEEP, 16'($urandom));
    write_reg(gso_pkg::CFG_GLIDE_TAKE, 16'($urandom));
    run_ticks(150, 1'b0);

    // Back to the power-on weights.
    settle();
    write_reg(gso_pkg::CFG_GLIDE_KEEP, gso_pkg::GLIDE_KEEP_RST);
    write_reg(gso_pkg::CFG_GLIDE_TAKE, gso_pkg::GLIDE_TAKE_RST);
    run_ticks(150, 1'b0);

    settle();
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/gso_pkg.sv
rtl/core/gso_front.sv
rtl/core/gso_back.sv
rtl/core/gliding_sine_oscillator_unit.sv
bench/gliding_sine_oscillator_unit_test.sv
